[rtl/elevator_dispatch_controller_top_macros.svh]
// Assertion macros used by the elevator dispatch checker.
`ifndef ELEVATOR_DISPATCH_CONTROLLER_TOP_MACROS_SVH
`define ELEVATOR_DISPATCH_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk, quiet while in reset
`define EDC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("elevator dispatch check failed");

// Next-cycle implication, sampled on i_clk, quiet while in reset
`define EDC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("elevator dispatch check failed");

`endif

[rtl/edc_pkg.sv]
// Types, constants and priority encoders for the elevator dispatch controller.
`timescale 1ns / 1ps

package edc_pkg;

    localparam int FLOOR_COUNT = 16;
    localparam int FLOOR_W     = 4;
    localparam int PEND_W      = 1 << FLOOR_W;
    localparam int SECS_W      = 4;
    localparam logic [FLOOR_W-1:0] TOP_FLOOR =
        (FLOOR_COUNT - 1 > PEND_W - 1) ? FLOOR_W'(PEND_W - 1) : FLOOR_W'(FLOOR_COUNT - 1);
    localparam logic [SECS_W-1:0] DOOR_SECS_LONG  = SECS_W'(10);
    localparam logic [SECS_W-1:0] DOOR_SECS_SHORT = SECS_W'(2);

    typedef enum logic [3:0] {
        OP_HALL_UP     = 4'd0,
        OP_HALL_DOWN   = 4'd1,
        OP_CAR_CALL    = 4'd2,
        OP_FLOOR_TICK  = 4'd3,
        OP_DOOR_CLOSED = 4'd4,
        OP_EMERGENCY   = 4'd5,
        OP_OPEN        = 4'd6,
        OP_CLOSE       = 4'd7,
        OP_OVERLOAD    = 4'd8,
        OP_NORMAL_LOAD = 4'd9
    } t_op;

    typedef enum logic [1:0] {
        MOTOR_NONE = 2'd0,
        MOTOR_UP   = 2'd1,
        MOTOR_DOWN = 2'd2,
        MOTOR_STOP = 2'd3
    } t_motor;

    typedef enum logic [1:0] {
        DOOR_NONE       = 2'd0,
        DOOR_OPEN_TIMED = 2'd1,
        DOOR_OPEN_HELD  = 2'd2,
        DOOR_CLOSE      = 2'd3
    } t_door;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } t_dir;

    typedef enum logic [1:0] {
        MSG_NONE     = 2'd0,
        MSG_LEAVE    = 2'd1,
        MSG_OVERLOAD = 2'd2,
        MSG_CLEAR    = 2'd3
    } t_msg;

    typedef enum logic [1:0] {
        ALERT_NONE      = 2'd0,
        ALERT_EMERGENCY = 2'd1,
        ALERT_FIRE      = 2'd2,
        ALERT_POWER     = 2'd3
    } t_alert;

    typedef enum logic [1:0] {
        KIND_GENERAL = 2'd0,
        KIND_FIRE    = 2'd1,
        KIND_POWER   = 2'd2
    } t_kind;

    // One input item
    typedef struct packed {
        t_op                op;
        logic [FLOOR_W-1:0] floor;
        logic [1:0]         kind;
        logic               door_is_closed;
        logic               overloaded;
        logic               hold_open;
    } t_item;

    // One result item
    typedef struct packed {
        t_motor             motor;
        t_door              door;
        logic [SECS_W-1:0]  door_secs;
        logic               bell;
        logic               arrived;
        logic               req_acc;
        logic               available;
        logic [FLOOR_W-1:0] floor_now;
        t_dir               dir;
        t_msg               msg;
        t_alert             alert;
    } t_result;

    // Car state carried from item to item
    typedef struct packed {
        logic [PEND_W-1:0]  pending;
        logic [FLOOR_W-1:0] car;
        logic [FLOOR_W-1:0] target;
        logic               target_valid;
        t_dir               heading;
        t_dir               motion;
        logic               emerg;
    } t_state;

    // Lowest set bit of the pending map, zero when empty
    function automatic logic [FLOOR_W-1:0] lowest_set(input logic [PEND_W-1:0] m);
        logic [FLOOR_W-1:0] idx;
        idx = '0;
        for (int i = PEND_W - 1; i >= 0; i--) begin
            if (m[i]) idx = FLOOR_W'(i);
        end
        return idx;
    endfunction

    // Highest set bit of the pending map, zero when empty
    function automatic logic [FLOOR_W-1:0] highest_set(input logic [PEND_W-1:0] m);
        logic [FLOOR_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < PEND_W; i++) begin
            if (m[i]) idx = FLOOR_W'(i);
        end
        return idx;
    endfunction

endpackage

[rtl/edc_step.sv]
// Next-state and result logic for one elevator event.
`timescale 1ns / 1ps

module edc_step
    import edc_pkg::*;
(
    input  t_state  i_state,
    input  t_item   i_item,
    output t_state  o_state,
    output t_result o_result
);

    t_state             ns;
    t_result            res;
    logic [PEND_W-1:0]  f_bit;
    logic [PEND_W-1:0]  add_pend;
    logic [PEND_W-1:0]  arr_pend;
    logic [FLOOR_W-1:0] ahead_target;
    logic [FLOOR_W-1:0] car_step;
    logic               req_ok;
    logic               do_start;
    logic               start_closed;

    // Precompute request merge, next car floor and arrival clear
    always_comb begin
        f_bit        = PEND_W'(1) << i_item.floor;
        add_pend     = i_state.pending | f_bit;
        ahead_target = (i_state.heading == DIR_UP) ? lowest_set(add_pend)
                                                   : highest_set(add_pend);
        req_ok       = !i_state.emerg && (i_item.floor <= TOP_FLOOR);
        arr_pend     = i_state.pending & ~(PEND_W'(1) << i_state.target);
        if (i_state.motion == DIR_UP && i_state.car < TOP_FLOOR) begin
            car_step = i_state.car + FLOOR_W'(1);
        end else if (i_state.motion == DIR_DOWN && i_state.car != '0) begin
            car_step = i_state.car - FLOOR_W'(1);
        end else begin
            car_step = i_state.car;
        end
    end

    // Decode the event and update state
    always_comb begin
        ns           = i_state;
        res          = '0;
        do_start     = 1'b0;
        start_closed = i_item.door_is_closed;

        case (i_item.op)
            OP_HALL_UP, OP_HALL_DOWN: begin
                do_start = 1'b1;
                if (req_ok) begin
                    if (i_state.pending == '0) begin
                        if (i_item.floor == i_state.car) begin
                            if (i_state.motion == DIR_STOP) begin
                                res.door      = DOOR_OPEN_TIMED;
                                res.door_secs = DOOR_SECS_LONG;
                            end
                            res.arrived = 1'b1;
                        end else begin
                            ns.pending      = add_pend;
                            ns.target       = i_item.floor;
                            ns.target_valid = 1'b1;
                            ns.heading      = (i_item.floor > i_state.car) ? DIR_UP : DIR_DOWN;
                        end
                        res.req_acc = 1'b1;
                    end else if (i_item.op == OP_HALL_UP && i_state.heading == DIR_UP &&
                                 i_item.floor > i_state.car) begin
                        ns.pending      = add_pend;
                        ns.target       = ahead_target;
                        ns.target_valid = 1'b1;
                        res.req_acc     = 1'b1;
                    end else if (i_item.op == OP_HALL_DOWN && i_state.heading == DIR_DOWN &&
                                 i_item.floor < i_state.car) begin
                        ns.pending      = add_pend;
                        ns.target       = ahead_target;
                        ns.target_valid = 1'b1;
                        res.req_acc     = 1'b1;
                    end
                end
            end
            OP_CAR_CALL: begin
                do_start = 1'b1;
                if (req_ok && i_item.floor != i_state.car) begin
                    if (i_state.pending == '0) begin
                        ns.pending      = add_pend;
                        ns.target       = i_item.floor;
                        ns.target_valid = 1'b1;
                        ns.heading      = (i_item.floor > i_state.car) ? DIR_UP : DIR_DOWN;
                    end else if ((i_state.heading == DIR_UP && i_item.floor > i_state.car) ||
                                 (i_state.heading == DIR_DOWN && i_item.floor < i_state.car)) begin
                        ns.pending      = add_pend;
                        ns.target       = ahead_target;
                        ns.target_valid = 1'b1;
                    end
                end
            end
            OP_FLOOR_TICK: begin
                ns.car = car_step;
                // Arrival: stop, ring, open and pick the next stop
                if (i_state.target_valid && car_step == i_state.target) begin
                    res.motor  = MOTOR_STOP;
                    ns.motion  = DIR_STOP;
                    ns.pending = arr_pend;
                    if (arr_pend == '0) begin
                        ns.heading      = DIR_STOP;
                        ns.target_valid = 1'b0;
                        ns.target       = '0;
                        res.available   = 1'b1;
                    end else if (i_state.heading == DIR_UP) begin
                        ns.target = lowest_set(arr_pend);
                    end else if (i_state.heading == DIR_DOWN) begin
                        ns.target = highest_set(arr_pend);
                    end
                    res.bell = 1'b1;
                    if (i_state.emerg) begin
                        res.door = DOOR_OPEN_HELD;
                        res.msg  = MSG_LEAVE;
                    end else begin
                        res.door      = DOOR_OPEN_TIMED;
                        res.door_secs = DOOR_SECS_LONG;
                    end
                    res.arrived = 1'b1;
                end
            end
            OP_DOOR_CLOSED: begin
                res.bell     = 1'b1;
                do_start     = 1'b1;
                start_closed = 1'b1;
            end
            OP_EMERGENCY: begin
                case (t_kind'(i_item.kind))
                    KIND_GENERAL: res.alert = ALERT_EMERGENCY;
                    KIND_FIRE:    res.alert = ALERT_FIRE;
                    KIND_POWER:   res.alert = ALERT_POWER;
                    default:      res.alert = ALERT_NONE;
                endcase
                ns.emerg = 1'b1;
                if (i_state.motion == DIR_STOP) begin
                    res.door = DOOR_OPEN_HELD;
                    res.msg  = MSG_LEAVE;
                end else begin
                    // Drop all requests and head for the next floor
                    ns.pending = '0;
                    if (i_state.motion == DIR_UP) begin
                        ns.target = (i_state.car < TOP_FLOOR) ? i_state.car + FLOOR_W'(1)
                                                              : i_state.car;
                    end else begin
                        ns.target = (i_state.car != '0) ? i_state.car - FLOOR_W'(1) : '0;
                    end
                    ns.target_valid = 1'b1;
                end
            end
            OP_OPEN: begin
                if (i_state.motion == DIR_STOP) begin
                    if (i_item.hold_open) begin
                        res.door = DOOR_OPEN_HELD;
                    end else begin
                        res.door      = DOOR_OPEN_TIMED;
                        res.door_secs = DOOR_SECS_LONG;
                    end
                end
            end
            OP_CLOSE: begin
                if (i_state.motion == DIR_STOP && !i_item.overloaded && !i_state.emerg) begin
                    res.door = DOOR_CLOSE;
                    res.msg  = MSG_CLEAR;
                end
            end
            OP_OVERLOAD: begin
                if (i_state.motion == DIR_STOP && !i_state.emerg) begin
                    res.door = DOOR_OPEN_HELD;
                    res.msg  = MSG_OVERLOAD;
                end
            end
            OP_NORMAL_LOAD: begin
                if (i_state.motion == DIR_STOP) begin
                    res.door      = DOOR_OPEN_TIMED;
                    res.door_secs = DOOR_SECS_SHORT;
                end
            end
            default: begin
            end
        endcase

        // Start a stopped car once the door is shut and a stop is pending
        if (do_start && ns.motion == DIR_STOP && ns.target_valid && start_closed) begin
            if (ns.heading == DIR_UP) begin
                ns.motion = DIR_UP;
                res.motor = MOTOR_UP;
            end else begin
                ns.motion = DIR_DOWN;
                res.motor = MOTOR_DOWN;
            end
        end

        res.floor_now = ns.car;
        res.dir       = ns.heading;
    end

    assign o_state  = ns;
    assign o_result = res;

endmodule

[rtl/elevator_dispatch_controller_top.sv]
// Top level of the single-car elevator dispatch controller.
`timescale 1ns / 1ps
// Usage:
//   Input channel: i_valid with payload i_operation, i_floor, i_emergency_kind,
//   i_door_is_closed, i_overloaded, i_hold_open; o_stall pushes back. An item
//   is taken at a clock edge with i_valid high and o_stall low.
//   Output channel: o_valid with one result item per input item; the receiver
//   holds i_stall high to keep the result on the ports unchanged.
//   An item taken is held in the input register; its result shows once it has
//   moved on into the output register.
//   Throughput: one item per cycle while the output side is not stalled. The car
//   state is read and written by the combinational update between the two
//   registers, so each item sees the state left by the one before it with no bubble.
//   Stall: while the output register is full and stalled, an item in the input
//   register waits there and o_stall rises; with the input register free one
//   more item is still taken.
//   Reset (i_rst_n low, synchronous): both registers empty, no requests, car at
//   floor 0, stopped, emergency latch clear. The latch is cleared only by reset.

module elevator_dispatch_controller_top
    import edc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [3:0]         i_operation,
    input  logic [FLOOR_W-1:0] i_floor,
    input  logic [1:0]         i_emergency_kind,
    input  logic               i_door_is_closed,
    input  logic               i_overloaded,
    input  logic               i_hold_open,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_motor_cmd,
    output logic [1:0]         o_door_cmd,
    output logic [SECS_W-1:0]  o_door_seconds,
    output logic               o_bell,
    output logic               o_arrived,
    output logic               o_request_accepted,
    output logic               o_available,
    output logic [FLOOR_W-1:0] o_floor_now,
    output logic [1:0]         o_travel_direction,
    output logic [1:0]         o_message,
    output logic [1:0]         o_alert
);

    t_item   r_in;
    logic    r_in_vld;
    t_result r_out;
    logic    r_out_vld;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    logic    w_adv;
    logic    w_in_acc;

    // Output register frees up when empty or being taken
    assign w_adv    = !r_out_vld || !i_stall;
    assign o_stall  = r_in_vld && !w_adv;
    assign w_in_acc = i_valid && !o_stall;

    edc_step u_step (
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Control: valid flags and car state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else begin
            if (w_in_acc) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld <= r_in_vld;
                if (r_in_vld) begin
                    r_state <= n_state;
                end
            end
        end
    end

    // Payload: capture the item and the result
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in.op             <= t_op'(i_operation);
            r_in.floor          <= i_floor;
            r_in.kind           <= i_emergency_kind;
            r_in.door_is_closed <= i_door_is_closed;
            r_in.overloaded     <= i_overloaded;
            r_in.hold_open      <= i_hold_open;
        end
        if (w_adv && r_in_vld) begin
            r_out <= n_result;
        end
    end

    assign o_valid            = r_out_vld;
    assign o_motor_cmd        = r_out.motor;
    assign o_door_cmd         = r_out.door;
    assign o_door_seconds     = r_out.door_secs;
    assign o_bell             = r_out.bell;
    assign o_arrived          = r_out.arrived;
    assign o_request_accepted = r_out.req_acc;
    assign o_available        = r_out.available;
    assign o_floor_now        = r_out.floor_now;
    assign o_travel_direction = r_out.dir;
    assign o_message          = r_out.msg;
    assign o_alert            = r_out.alert;

endmodule

[rtl/edc_checker.sv]
// Port-level checker for the elevator dispatch controller, bound to the top level.
`timescale 1ns / 1ps
`include "elevator_dispatch_controller_top_macros.svh"

module edc_checker
    import edc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic [3:0]         i_operation,
    input logic [FLOOR_W-1:0] i_floor,
    input logic [1:0]         i_emergency_kind,
    input logic               i_door_is_closed,
    input logic               i_overloaded,
    input logic               i_hold_open,
    input logic               o_valid,
    input logic               i_stall,
    input logic [1:0]         o_motor_cmd,
    input logic [1:0]         o_door_cmd,
    input logic [SECS_W-1:0]  o_door_seconds,
    input logic               o_bell,
    input logic               o_arrived,
    input logic               o_request_accepted,
    input logic               o_available,
    input logic [FLOOR_W-1:0] o_floor_now,
    input logic [1:0]         o_travel_direction,
    input logic [1:0]         o_message,
    input logic [1:0]         o_alert
);

    // A stalled result stays put
    `EDC_ASSERT_NEXT(a_stall_hold, o_valid && i_stall, o_valid && $stable(o_motor_cmd) && $stable(o_door_cmd) && $stable(o_floor_now) && $stable(o_travel_direction))

    // Only a timed opening carries a door time
    `EDC_ASSERT_NOW(a_door_secs, o_valid && o_door_cmd != DOOR_OPEN_TIMED, o_door_seconds == '0)

    // Starting upward always matches an upward heading
    `EDC_ASSERT_NOW(a_up_heading, o_valid && o_motor_cmd == MOTOR_UP, o_travel_direction == DIR_UP)

    // Serving the last stop stops the car, rings and leaves it without heading
    `EDC_ASSERT_NOW(a_avail_stop, o_valid && o_available, o_motor_cmd == MOTOR_STOP && o_bell && o_arrived && o_travel_direction == DIR_STOP)

endmodule

bind elevator_dispatch_controller_top edc_checker u_edc_checker (.*);

[dv/testbench.sv]
// Self-checking testbench for the elevator dispatch controller top level.
`timescale 1ns / 1ps

module testbench;
    import edc_pkg::*;

    localparam int         IDLE_LIMIT = 2000;
    localparam logic [3:0] OP_FIRST_SPARE = 4'd10;
    localparam logic [3:0] OP_LAST_SPARE  = 4'd15;
    localparam logic [1:0] KIND_SILENT    = 2'd3;

    // Car state tracker: predicts the command set for each event and holds it until it shows
    class car_tracker;
        logic [PEND_W-1:0]  calls;
        logic [FLOOR_W-1:0] car_at;
        logic [FLOOR_W-1:0] dest;
        logic               dest_ok;
        t_dir               head;
        t_dir               run;
        logic               latched;
        t_result            resp;
        t_result            owed[$];
        int                 errors;

        function new();
            calls   = '0;
            car_at  = '0;
            dest    = '0;
            dest_ok = 1'b0;
            head    = DIR_STOP;
            run     = DIR_STOP;
            latched = 1'b0;
            errors  = 0;
        endfunction

        // Scan the call map from the bottom when going up, from the top otherwise
        function logic [FLOOR_W-1:0] nearest_call(input logic upward);
            int idx;
            for (int i = 0; i < PEND_W; i++) begin
                idx = upward ? i : PEND_W - 1 - i;
                if (calls[idx]) return FLOOR_W'(idx);
            end
            return '0;
        endfunction

        function void claim_first(input logic [FLOOR_W-1:0] f);
            calls[f] = 1'b1;
            dest     = f;
            dest_ok  = 1'b1;
            head     = (f > car_at) ? DIR_UP : DIR_DOWN;
        endfunction

        function void claim_ahead(input logic [FLOOR_W-1:0] f);
            calls[f] = 1'b1;
            dest     = nearest_call(head == DIR_UP);
            dest_ok  = 1'b1;
        endfunction

        // Set the motor going once a stopped car has somewhere to go and the door is shut
        function void try_start(input logic closed);
            if (run == DIR_STOP && dest_ok && closed) begin
                if (head == DIR_UP) begin
                    run        = DIR_UP;
                    resp.motor = MOTOR_UP;
                end else begin
                    run        = DIR_DOWN;
                    resp.motor = MOTOR_DOWN;
                end
            end
        endfunction

        function void hall_call(input logic [FLOOR_W-1:0] f, input logic up);
            if (latched || f > TOP_FLOOR) return;
            if (calls == '0) begin
                // an empty car called to its own floor just opens up
                if (f == car_at) begin
                    if (run == DIR_STOP) begin
                        resp.door      = DOOR_OPEN_TIMED;
                        resp.door_secs = DOOR_SECS_LONG;
                    end
                    resp.arrived = 1'b1;
                end else begin
                    claim_first(f);
                end
                resp.req_acc = 1'b1;
            end else if (up && head == DIR_UP && f > car_at) begin
                claim_ahead(f);
                resp.req_acc = 1'b1;
            end else if (!up && head == DIR_DOWN && f < car_at) begin
                claim_ahead(f);
                resp.req_acc = 1'b1;
            end
        endfunction

        function void car_call(input logic [FLOOR_W-1:0] f);
            if (latched || f > TOP_FLOOR || f == car_at) return;
            if (calls == '0) claim_first(f);
            else if (head == DIR_UP && f > car_at) claim_ahead(f);
            else if (head == DIR_DOWN && f < car_at) claim_ahead(f);
        endfunction

        // Stop at the destination, drop its call and pick the next one
        function void stop_here();
            resp.motor  = MOTOR_STOP;
            run         = DIR_STOP;
            calls[dest] = 1'b0;
            if (calls == '0) begin
                head           = DIR_STOP;
                dest_ok        = 1'b0;
                dest           = '0;
                resp.available = 1'b1;
            end else if (head == DIR_UP) begin
                dest = nearest_call(1'b1);
            end else if (head == DIR_DOWN) begin
                dest = nearest_call(1'b0);
            end
            resp.bell = 1'b1;
            if (latched) begin
                resp.door = DOOR_OPEN_HELD;
                resp.msg  = MSG_LEAVE;
            end else begin
                resp.door      = DOOR_OPEN_TIMED;
                resp.door_secs = DOOR_SECS_LONG;
            end
            resp.arrived = 1'b1;
        endfunction

        function void note_event(input t_item it);
            resp = '0;
            case (it.op)
                OP_HALL_UP, OP_HALL_DOWN: begin
                    hall_call(it.floor, it.op == OP_HALL_UP);
                    try_start(it.door_is_closed);
                end
                OP_CAR_CALL: begin
                    car_call(it.floor);
                    try_start(it.door_is_closed);
                end
                OP_FLOOR_TICK: begin
                    // step the car, holding it at the shaft ends
                    if (run == DIR_UP && car_at < TOP_FLOOR) car_at = car_at + 1'b1;
                    else if (run == DIR_DOWN && car_at > 0) car_at = car_at - 1'b1;
                    if (dest_ok && car_at == dest) stop_here();
                end
                OP_DOOR_CLOSED: begin
                    resp.bell = 1'b1;
                    try_start(1'b1);
                end
                OP_EMERGENCY: begin
                    case (it.kind)
                        KIND_GENERAL: resp.alert = ALERT_EMERGENCY;
                        KIND_FIRE:    resp.alert = ALERT_FIRE;
                        KIND_POWER:   resp.alert = ALERT_POWER;
                        default:      resp.alert = ALERT_NONE;
                    endcase
                    latched = 1'b1;
                    if (run == DIR_STOP) begin
                        resp.door = DOOR_OPEN_HELD;
                        resp.msg  = MSG_LEAVE;
                    end else begin
                        // drop all calls and head for the next floor along
                        calls = '0;
                        if (run == DIR_UP)
                            dest = (car_at < TOP_FLOOR) ? car_at + 1'b1 : car_at;
                        else
                            dest = (car_at > 0) ? car_at - 1'b1 : '0;
                        dest_ok = 1'b1;
                    end
                end
                OP_OPEN: begin
                    if (run == DIR_STOP) begin
                        if (it.hold_open) begin
                            resp.door = DOOR_OPEN_HELD;
                        end else begin
                            resp.door      = DOOR_OPEN_TIMED;
                            resp.door_secs = DOOR_SECS_LONG;
                        end
                    end
                end
                OP_CLOSE: begin
                    if (run == DIR_STOP && !it.overloaded && !latched) begin
                        resp.door = DOOR_CLOSE;
                        resp.msg  = MSG_CLEAR;
                    end
                end
                OP_OVERLOAD: begin
                    if (run == DIR_STOP && !latched) begin
                        resp.door = DOOR_OPEN_HELD;
                        resp.msg  = MSG_OVERLOAD;
                    end
                end
                OP_NORMAL_LOAD: begin
                    if (run == DIR_STOP) begin
                        resp.door      = DOOR_OPEN_TIMED;
                        resp.door_secs = DOOR_SECS_SHORT;
                    end
                end
                default: ;
            endcase
            resp.floor_now = car_at;
            resp.dir       = head;
            owed.push_back(resp);
        endfunction

        function void compare_field(input string name, input int want, input int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_output(input t_result got);
            t_result want;
            if (owed.size() == 0) begin
                $display("%0t: result item with nothing outstanding", $time);
                errors++;
                return;
            end
            want = owed.pop_front();
            compare_field("motor_cmd", want.motor, got.motor);
            compare_field("door_cmd", want.door, got.door);
            compare_field("door_seconds", want.door_secs, got.door_secs);
            compare_field("bell", want.bell, got.bell);
            compare_field("arrived", want.arrived, got.arrived);
            compare_field("request_accepted", want.req_acc, got.req_acc);
            compare_field("available", want.available, got.available);
            compare_field("floor_now", want.floor_now, got.floor_now);
            compare_field("travel_direction", want.dir, got.dir);
            compare_field("message", want.msg, got.msg);
            compare_field("alert", want.alert, got.alert);
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [3:0]         i_operation;
    logic [FLOOR_W-1:0] i_floor;
    logic [1:0]         i_emergency_kind;
    logic               i_door_is_closed;
    logic               i_overloaded;
    logic               i_hold_open;
    logic               o_valid;
    logic               i_stall;
    logic [1:0]         o_motor_cmd;
    logic [1:0]         o_door_cmd;
    logic [SECS_W-1:0]  o_door_seconds;
    logic               o_bell;
    logic               o_arrived;
    logic               o_request_accepted;
    logic               o_available;
    logic [FLOOR_W-1:0] o_floor_now;
    logic [1:0]         o_travel_direction;
    logic [1:0]         o_message;
    logic [1:0]         o_alert;

    car_tracker board;
    int         send_idle_pct;
    int         hold_pct;
    int         quiet;

    elevator_dispatch_controller_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_operation        (i_operation),
        .i_floor            (i_floor),
        .i_emergency_kind   (i_emergency_kind),
        .i_door_is_closed   (i_door_is_closed),
        .i_overloaded       (i_overloaded),
        .i_hold_open        (i_hold_open),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_motor_cmd        (o_motor_cmd),
        .o_door_cmd         (o_door_cmd),
        .o_door_seconds     (o_door_seconds),
        .o_bell             (o_bell),
        .o_arrived          (o_arrived),
        .o_request_accepted (o_request_accepted),
        .o_available        (o_available),
        .o_floor_now        (o_floor_now),
        .o_travel_direction (o_travel_direction),
        .o_message          (o_message),
        .o_alert            (o_alert)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Stall the result side at random
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < hold_pct);
    end

    // Check each result taken and watch for a hung handshake
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                board.check_output({o_motor_cmd, o_door_cmd, o_door_seconds, o_bell,
                                    o_arrived, o_request_accepted, o_available,
                                    o_floor_now, o_travel_direction, o_message, o_alert});
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet = 0;
            else quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic t_item mk(input t_op op, input int f, input int kind,
                                 input bit closed, input bit over, input bit hold);
        t_item it;
        it.op             = op;
        it.floor          = FLOOR_W'(f);
        it.kind           = 2'(kind);
        it.door_is_closed = closed;
        it.overloaded     = over;
        it.hold_open      = hold;
        return it;
    endfunction

    // Weighted mix: many calls and floor ticks so trips run to completion
    function automatic t_item random_event(input bit with_emergency);
        t_item it;
        int    pick;
        it = mk(OP_FLOOR_TICK, $urandom_range(PEND_W - 1), $urandom_range(3),
                $urandom_range(1), $urandom_range(1), $urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 12)      it.op = OP_HALL_UP;
        else if (pick < 24) it.op = OP_HALL_DOWN;
        else if (pick < 36) it.op = OP_CAR_CALL;
        else if (pick < 68) it.op = OP_FLOOR_TICK;
        else if (pick < 78) it.op = OP_DOOR_CLOSED;
        else if (pick < 82) it.op = OP_OPEN;
        else if (pick < 86) it.op = OP_CLOSE;
        else if (pick < 89) it.op = OP_OVERLOAD;
        else if (pick < 92) it.op = OP_NORMAL_LOAD;
        else if (pick < 96) it.op = t_op'($urandom_range(OP_LAST_SPARE, OP_FIRST_SPARE));
        else                it.op = with_emergency ? OP_EMERGENCY : OP_FLOOR_TICK;
        return it;
    endfunction

    // Offer one item after a random gap and hold it until taken
    task automatic send_item(input t_item it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        @(negedge i_clk);
        repeat (gap) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_operation      <= it.op;
        i_floor          <= it.floor;
        i_emergency_kind <= it.kind;
        i_door_is_closed <= it.door_is_closed;
        i_overloaded     <= it.overloaded;
        i_hold_open      <= it.hold_open;
        do @(posedge i_clk); while (o_stall);
        board.note_event(it);
    endtask

    // Hold the input side until every outstanding result has come back
    task automatic wait_for_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (board.owed.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_directed();
        // spare opcode with every field at its top value
        send_item(mk(t_op'(OP_LAST_SPARE), PEND_W - 1, KIND_SILENT, 1, 1, 1));
        // hall call to the floor the empty car stands at
        send_item(mk(OP_HALL_UP, 0, KIND_GENERAL, 0, 0, 0));
        // door handling while stopped
        send_item(mk(OP_NORMAL_LOAD, 0, KIND_GENERAL, 0, 0, 0));
        send_item(mk(OP_OVERLOAD, 0, KIND_GENERAL, 0, 1, 0));
        send_item(mk(OP_CLOSE, 0, KIND_GENERAL, 0, 1, 0));
        send_item(mk(OP_CLOSE, 0, KIND_GENERAL, 0, 0, 0));
        send_item(mk(OP_OPEN, 0, KIND_GENERAL, 0, 0, 1));
        send_item(mk(OP_OPEN, 0, KIND_GENERAL, 0, 0, 0));
        // car call to own floor, then a first call that leaves the door open
        send_item(mk(OP_CAR_CALL, 0, KIND_GENERAL, 1, 0, 0));
        send_item(mk(OP_CAR_CALL, 4, KIND_GENERAL, 0, 0, 0));
        // down call against the heading is refused
        send_item(mk(OP_HALL_DOWN, PEND_W - 1, KIND_GENERAL, 0, 0, 0));
        // up call ahead becomes the next stop and starts the car
        send_item(mk(OP_HALL_UP, 2, KIND_GENERAL, 1, 0, 0));
        // door requests while moving are ignored
        send_item(mk(OP_OPEN, 0, KIND_GENERAL, 0, 0, 1));
        send_item(mk(OP_CLOSE, 0, KIND_GENERAL, 0, 0, 0));
        repeat (2) send_item(mk(OP_FLOOR_TICK, 0, KIND_GENERAL, 0, 0, 0));
        // door-closed report restarts towards the remaining call
        send_item(mk(OP_DOOR_CLOSED, 0, KIND_GENERAL, 0, 0, 0));
        repeat (2) send_item(mk(OP_FLOOR_TICK, 0, KIND_GENERAL, 0, 0, 0));
        // down call from an empty car starts at once
        send_item(mk(OP_HALL_DOWN, 0, KIND_GENERAL, 1, 0, 0));
        repeat (4) send_item(mk(OP_FLOOR_TICK, 0, KIND_GENERAL, 0, 0, 0));
        // tick on a stopped car
        send_item(mk(OP_FLOOR_TICK, 0, KIND_GENERAL, 0, 0, 0));
    endtask

    // The latch never clears, so emergencies come last
    task automatic run_emergency();
        int guard;
        int far;
        guard = 0;
        // serve every open call so the car stands empty
        while (board.calls != '0 && guard < 64) begin
            send_item(mk(board.run == DIR_STOP ? OP_DOOR_CLOSED : OP_FLOOR_TICK,
                         0, KIND_GENERAL, 1, 0, 0));
            guard++;
        end
        far = (board.car_at >= PEND_W / 2) ? 0 : int'(TOP_FLOOR);
        send_item(mk(OP_CAR_CALL, far, KIND_GENERAL, 0, 0, 0));
        // silent emergency on a stopped car keeps its destination
        send_item(mk(OP_EMERGENCY, 0, KIND_SILENT, 0, 0, 0));
        send_item(mk(OP_HALL_UP, $urandom_range(PEND_W - 1), KIND_GENERAL, 0, 0, 0));
        send_item(mk(OP_CLOSE, 0, KIND_GENERAL, 0, 0, 0));
        send_item(mk(OP_OVERLOAD, 0, KIND_GENERAL, 0, 1, 0));
        send_item(mk(OP_DOOR_CLOSED, 0, KIND_GENERAL, 0, 0, 0));
        // emergency while moving sends the car to the next floor
        send_item(mk(OP_EMERGENCY, 0, $urandom_range(2), 0, 0, 0));
        send_item(mk(OP_FLOOR_TICK, 0, KIND_GENERAL, 0, 0, 0));
        repeat (40) send_item(random_event(1'b1));
    endtask

    initial begin
        board            = new();
        quiet            = 0;
        send_idle_pct    = 0;
        hold_pct         = 0;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_stall          = 1'b0;
        i_operation      = '0;
        i_floor          = '0;
        i_emergency_kind = '0;
        i_door_is_closed = 1'b0;
        i_overloaded     = 1'b0;
        i_hold_open      = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // no idling on either side
        run_directed();
        repeat (100) send_item(random_event(1'b0));
        wait_for_results();

        // sparse input
        send_idle_pct = 79;
        repeat (100) send_item(random_event(1'b0));
        wait_for_results();

        // heavy back-pressure
        send_idle_pct = 0;
        hold_pct      = 79;
        repeat (100) send_item(random_event(1'b0));
        wait_for_results();

        // light idling on both sides, then the emergency sequence
        send_idle_pct = 18;
        hold_pct      = 18;
        repeat (100) send_item(random_event(1'b0));
        run_emergency();
        wait_for_results();
        repeat (4) @(posedge i_clk);

        if (board.errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/edc_pkg.sv
rtl/edc_step.sv
rtl/elevator_dispatch_controller_top.sv
rtl/edc_checker.sv
dv/testbench.sv
